@@ hdl/cursor_level_moving_average_defines.svh @@
// Assertion macros for the cursor level moving average block.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef CURSOR_LEVEL_MOVING_AVERAGE_DEFINES_SVH
`define CURSOR_LEVEL_MOVING_AVERAGE_DEFINES_SVH
`ifndef SYNTH
`define CLMA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("clma assertion failed");
`define CLMA_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("clma reset assertion failed");
`else
`define CLMA_ASSERT(label, clk, rst_n, prop)
`define CLMA_ASSERT_RST(label, clk, prop)
`endif
`endif

@@ hdl/clma_pkg.sv @@
// Package for the cursor level moving average block: sizes and sequencer states.
// No dependencies.
`default_nettype none
package clma_pkg;

  localparam int unsigned MAX_WINDOW = 32768;
  localparam int unsigned PTR_W      = $clog2(MAX_WINDOW);
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned BIN_W      = 16;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned DIV_STEPS  = SUM_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int unsigned REM_W      = CNT_W + 1;

  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_WINDOW);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_APPEND,
    ST_TRIM,
    ST_DROP_RD,
    ST_DROP_SUB,
    ST_DIV,
    ST_WB
  } clma_state_e;

endpackage
`default_nettype wire

@@ hdl/cursor_level_moving_average.sv @@
// Sliding boxcar mean of Q8.8 level samples per spectrum bin.
// Each accepted beat is appended to the ring, then the oldest samples are dropped,
// each by a registered ring read and a subtract; a bit-serial 32-step divider then
// forms the mean. Input accepted only while idle, once the result is registered.
// Reset clears sum, count, pointer, bin and output valid; ring contents stay undefined.
// Uses clma_pkg and cursor_level_moving_average_defines.svh.
`default_nettype none
`include "cursor_level_moving_average_defines.svh"
module cursor_level_moving_average (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,    // window_length
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [15:0] level_db, [31:16] bin_index
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata    // [15:0] average_db, [31:16] sample_count
);
  import clma_pkg::*;

  clma_state_e state_q, state_d;

  logic [CNT_W-1:0]    wlen_q;
  logic [CNT_W-1:0]    limit;
  logic [SAMPLE_W-1:0] level_q;
  logic [BIN_W:0]      prev_bin_q;
  logic [SUM_W-1:0]    sum_q;
  logic [CNT_W-1:0]    count_q;
  logic [PTR_W-1:0]    ptr_q;
  logic                pre_drop_q;
  logic [SUM_W-1:0]    dvd_q;
  logic [REM_W-1:0]    rem_q;
  logic                neg_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [SAMPLE_W-1:0] rd_data_q;
  logic [SAMPLE_W-1:0] ring_mem [MAX_WINDOW];
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_avg_q;
  logic [CNT_W-1:0]    out_cnt_q;

  logic                in_fire;
  logic                mem_we;
  logic                mem_re;
  logic [PTR_W-1:0]    wr_addr;
  logic [REM_W-1:0]    rem_shift;
  logic [REM_W:0]      rem_diff;
  logic                q_bit;
  logic [SUM_W-1:0]    sum_mag;
  logic [SUM_W-1:0]    quot_signed;
  logic                out_free;

  always_comb begin
    if (wlen_q == '0) begin
      limit = CNT_W'(1);
    end else if (wlen_q > MAX_COUNT) begin
      limit = MAX_COUNT;
    end else begin
      limit = wlen_q;
    end
  end

  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign wr_addr     = ptr_q + count_q[PTR_W-1:0];
  assign rem_shift   = {rem_q[REM_W-2:0], dvd_q[SUM_W-1]};
  assign rem_diff    = {1'b0, rem_shift} - {2'b00, count_q};
  assign q_bit       = !rem_diff[REM_W];
  assign sum_mag     = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
  assign quot_signed = neg_q ? (~dvd_q + SUM_W'(1)) : dvd_q;
  assign out_free    = !out_valid_q || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_fire) state_d = ST_PRE;
      ST_PRE:      state_d = (count_q == MAX_COUNT) ? ST_DROP_RD : ST_APPEND;
      ST_APPEND:   state_d = ST_TRIM;
      ST_TRIM:     state_d = (count_q > limit) ? ST_DROP_RD : ST_DIV;
      ST_DROP_RD:  state_d = ST_DROP_SUB;
      ST_DROP_SUB: state_d = pre_drop_q ? ST_APPEND : ST_TRIM;
      ST_DIV:      if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = ST_WB;
      ST_WB:       if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    unique case (state_q)
      ST_IDLE:    s_axis_tready = 1'b1;
      ST_APPEND:  mem_we = 1'b1;
      ST_DROP_RD: mem_re = 1'b1;
      default:    ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= CNT_W'(1);
    end else if (cfg_we_i) begin
      wlen_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[wr_addr] <= level_q;
    end
    if (mem_re) begin
      rd_data_q <= ring_mem[ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_bin_q <= '1;
      sum_q      <= '0;
      count_q    <= '0;
      ptr_q      <= '0;
      pre_drop_q <= 1'b0;
      div_cnt_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire && ({1'b0, s_axis_tdata[31:16]} != prev_bin_q)) begin
            prev_bin_q <= {1'b0, s_axis_tdata[31:16]};
            sum_q      <= '0;
            count_q    <= '0;
            ptr_q      <= '0;
          end
        end
        ST_PRE: begin
          pre_drop_q <= (count_q == MAX_COUNT);
        end
        ST_APPEND: begin
          pre_drop_q <= 1'b0;
          count_q    <= count_q + CNT_W'(1);
          sum_q      <= sum_q + {{(SUM_W-SAMPLE_W){level_q[SAMPLE_W-1]}}, level_q};
        end
        ST_TRIM: begin
          div_cnt_q <= '0;
        end
        ST_DROP_SUB: begin
          count_q <= count_q - CNT_W'(1);
          sum_q   <= sum_q - {{(SUM_W-SAMPLE_W){rd_data_q[SAMPLE_W-1]}}, rd_data_q};
          ptr_q   <= ptr_q + PTR_W'(1);
        end
        ST_DIV: begin
          div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      level_q <= s_axis_tdata[15:0];
    end
    if (state_q == ST_TRIM) begin
      neg_q <= sum_q[SUM_W-1];
      dvd_q <= sum_mag;
      rem_q <= '0;
    end else if (state_q == ST_DIV) begin
      dvd_q <= {dvd_q[SUM_W-2:0], q_bit};
      rem_q <= q_bit ? rem_diff[REM_W-1:0] : rem_shift;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_WB && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WB && out_free) begin
      out_avg_q <= quot_signed[SAMPLE_W-1:0];
      out_cnt_q <= count_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_cnt_q, out_avg_q};

  `CLMA_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= MAX_COUNT)
  `CLMA_ASSERT(a_div_nonzero, clk_i, rst_ni, (state_q == ST_DIV) |-> (count_q != '0 && count_q <= limit))
  `CLMA_ASSERT(a_drop_nonempty, clk_i, rst_ni, (state_q == ST_DROP_SUB) |-> (count_q != '0))
  `CLMA_ASSERT(a_out_count, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tdata[31:16] != '0))
  `CLMA_ASSERT_RST(a_reset_quiet, clk_i, !rst_ni |=> !m_axis_tvalid)

endmodule
`default_nettype wire

@@ bench/tb_cursor_level_moving_average.sv @@
// Testbench for cursor_level_moving_average: directed and random level beats against
// a built-in windowed-mean predictor, with random stalls on both stream sides.
// Depends on clma_pkg and the RTL of the block only.
module tb_cursor_level_moving_average;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING_DEPTH = clma_pkg::MAX_WINDOW;
  localparam int unsigned WANT_DEPTH = 16;

  typedef struct packed {
    logic [15:0]        count;
    logic signed [15:0] mean;
  } level_avg_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [15:0] cfg_wdata_i   = '0;    // window_length
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;    // [15:0] level_db, [31:16] bin_index
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [31:0] m_axis_tdata;          // [15:0] average_db, [31:16] sample_count

  cursor_level_moving_average u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // predictor state
  logic [15:0]  lvl_ring [RING_DEPTH];
  longint       run_sum     = 0;
  int unsigned  run_count   = 0;
  int unsigned  head_ptr    = 0;
  logic [16:0]  last_bin    = 17'h1FFFF;
  logic [15:0]  win_len_reg = 16'd1;

  level_avg_t   want_fifo [WANT_DEPTH];
  int unsigned  want_wr        = 0;
  int unsigned  want_rd        = 0;
  int unsigned  fail_count     = 0;
  bit           send_gaps_on   = 1'b1;
  bit           sink_stalls_on = 1'b1;
  logic [15:0]  current_bin    = '0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void evict_oldest();
    run_sum   -= longint'($signed(lvl_ring[head_ptr % RING_DEPTH]));
    run_count -= 1;
    head_ptr   = (head_ptr + 1) % RING_DEPTH;
  endfunction

  function automatic level_avg_t average_next(logic [15:0] level, logic [15:0] bin);
    int unsigned limit;
    level_avg_t  res;
    limit = win_len_reg;
    if (limit < 1) limit = 1;
    if (limit > RING_DEPTH) limit = RING_DEPTH;
    if ({1'b0, bin} != last_bin) begin
      run_count = 0;
      run_sum   = 0;
      head_ptr  = 0;
      last_bin  = {1'b0, bin};
    end
    if (run_count >= RING_DEPTH) evict_oldest();
    lvl_ring[(head_ptr + run_count) % RING_DEPTH] = level;
    run_count += 1;
    run_sum   += longint'($signed(level));
    while (run_count > limit) evict_oldest();
    res.mean  = 16'(run_sum / longint'(run_count));
    res.count = 16'(run_count);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < 100) $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic send_sample(input logic [15:0] level, input logic [15:0] bin);
    if (send_gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {bin, level};
    do @(posedge clk_i); while (!s_axis_tready);
    want_fifo[want_wr % WANT_DEPTH] = average_next(level, bin);
    want_wr++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (want_wr != want_rd) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [15:0] len);
    cfg_wdata_i <= len;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    win_len_reg = len;
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // drain results, hold tready low in random bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (sink_stalls_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    level_avg_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (want_wr == want_rd) begin
        report_mismatch($sformatf("unexpected result beat %h", m_axis_tdata));
      end else begin
        want = want_fifo[want_rd % WANT_DEPTH];
        want_rd++;
        if (m_axis_tdata[15:0] !== want.mean)
          report_mismatch($sformatf("average_db got %h expected %h",
                                    m_axis_tdata[15:0], want.mean));
        if (m_axis_tdata[31:16] !== want.count)
          report_mismatch($sformatf("sample_count got %0d expected %0d",
                                    m_axis_tdata[31:16], want.count));
      end
    end
  end

  task automatic test_level_extremes();
    send_sample(16'h7FFF, 16'd0);
    send_sample(16'h8000, 16'd0);
    send_sample(16'h0000, 16'hFFFF);
    send_sample(16'hFFFF, 16'hFFFF);
    settle();
  endtask

  task automatic test_zero_length();
    set_window(16'd0);
    send_sample(16'd100, 16'd7);
    send_sample(-16'sd100, 16'd7);
    settle();
  endtask

  task automatic test_truncation();
    set_window(16'd2);
    send_sample(16'hFFFF, 16'd9);
    send_sample(16'h0000, 16'd9);
    send_sample(-16'sd3, 16'd9);
    send_sample(16'h8000, 16'd9);
    send_sample(16'h8000, 16'd9);
    send_sample(16'h7FFF, 16'd9);
    send_sample(16'h7FFF, 16'd9);
    settle();
  endtask

  task automatic test_length_saturation_and_decrease();
    set_window(16'hFFFF);
    for (int i = 1; i <= 6; i++) send_sample(16'(i), 16'd11);
    settle();
    set_window(16'd2);
    send_sample(16'd7, 16'd11);
    settle();
  endtask

  task automatic test_bin_change();
    send_sample(16'd8, 16'd12);
    send_sample(16'd3, 16'd11);
    settle();
  endtask

  function automatic logic [15:0] rand_level();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'($urandom_range(0, 8) - 4);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_random_items(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 11) == 0) current_bin = 16'($urandom_range(0, 65535));
      else if ($urandom_range(0, 39) == 0) current_bin = current_bin + 16'd1;
      send_sample(rand_level(), current_bin);
    end
  endtask

  task automatic test_random_runs();
    logic [15:0] lengths [13] = '{16'd2, 16'd16, 16'd0, 16'd100, 16'd3, 16'hFFFF, 16'd5,
                                  16'd32768, 16'd1, 16'd31, 16'd40000, 16'd4, 16'd7};
    foreach (lengths[k]) begin
      set_window(lengths[k]);
      send_gaps_on   = ($urandom_range(0, 3) != 0);
      sink_stalls_on = ($urandom_range(0, 3) != 0);
      send_random_items(60);
      settle();
    end
  endtask

  task automatic test_streaming();
    send_gaps_on   = 1'b0;
    sink_stalls_on = 1'b0;
    set_window(16'd8);
    send_random_items(150);
    settle();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_level_extremes();
    test_zero_length();
    test_truncation();
    test_length_saturation_and_decrease();
    test_bin_change();
    test_random_runs();
    test_streaming();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
